/* rtl/md5he_pkg.sv */
// ----------------------------------------------------------------------------
// md5he_pkg
// Shared widths, constants and round helpers of the MD5 hash engine.
// ----------------------------------------------------------------------------
package md5he_pkg;

   localparam int WORD_W    = 32;
   localparam int BLK_WORDS = 16;
   localparam int BLK_AW    = $clog2(BLK_WORDS);
   localparam int LEN_W     = 64;

   localparam logic [WORD_W-1:0] PAD_MARK = 32'h0000_0080;

   localparam logic [WORD_W-1:0] INIT_VEC [4] = '{
      32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476
   };

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word index used by round r
   function automatic logic [BLK_AW-1:0] msg_index(input logic [5:0] r);
      logic [BLK_AW-1:0] rl;
      logic [BLK_AW-1:0] g;
      rl = r[BLK_AW-1:0];
      case (r[5:4])
         2'd0: g = rl;
         2'd1: g = BLK_AW'(rl * 4'd5) + 4'd1;
         2'd2: g = BLK_AW'(rl * 4'd3) + 4'd5;
         2'd3: g = BLK_AW'(rl * 4'd7);
         default: g = rl;
      endcase
      return g;
   endfunction

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input logic [4:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} >> (6'd32 - {1'b0, s});
      return dbl[WORD_W-1:0];
   endfunction

endpackage

/* rtl/md5he_ram.sv */
// ----------------------------------------------------------------------------
// md5he_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5he_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/md5_hash_engine_core.sv */
// ----------------------------------------------------------------------------
// md5_hash_engine_core
// MD5 digest over a stream of little-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Each message word is written into a 16-entry block RAM; input is taken
// only in the idle state. When the block fills, input stalls for the
// compression: a priming RAM read, 64 rounds at one round per cycle (one RAM
// read per round), and an add into the chaining words. The last word of a
// message starts padding, which writes each remaining block word; then come
// one or two compressions, after which the four digest words are shown on
// the rsp side, word 0 (A) first, with tlast on word 3. A new message may
// start while the digest is still being drained; its closing chaining add
// waits until the previous digest has left.
// ----------------------------------------------------------------------------
module md5_hash_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [md5he_pkg::WORD_W-1:0] req_tdata,   // [31:0] data_word
   input  logic                        req_tlast,   // is_last
   input  logic [2:0]                  req_tuser,   // [2:0] byte_count
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [md5he_pkg::WORD_W-1:0] rsp_tdata,   // [31:0] digest_word
   output logic                        rsp_tlast,   // digest_end
   output logic [1:0]                  rsp_tuser    // [1:0] word_index
);

   import md5he_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PAD  = 4'b0010,
      S_CMP  = 4'b0100,
      S_ADD  = 4'b1000
   } state_type;

   localparam logic [BLK_AW-1:0] IDX_LEN_LO = BLK_AW'(BLK_WORDS - 2);
   localparam logic [BLK_AW-1:0] IDX_LAST   = BLK_AW'(BLK_WORDS - 1);
   localparam logic [6:0]        RND_DONE   = 7'd64;

   state_type          state_ff, state_in;
   logic [BLK_AW-1:0]  wcnt_ff, wcnt_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [6:0]         cnt_ff, cnt_in;
   logic               pad_ff, pad_in;
   logic               mark_ff, mark_in;
   logic               lenblk_ff, lenblk_in;
   logic               final_ff, final_in;
   logic               ovld_ff, ovld_in;
   logic [1:0]         oidx_ff, oidx_in;
   logic [WORD_W-1:0]  chain_ff [4];
   logic [WORD_W-1:0]  chain_in [4];
   logic [WORD_W-1:0]  dig_ff [4];
   logic [WORD_W-1:0]  dig_in [4];
   logic [WORD_W-1:0]  a_ff, b_ff, c_ff, d_ff;
   logic [WORD_W-1:0]  a_in, b_in, c_in, d_in;

   logic               wr_en;
   logic [WORD_W-1:0]  wr_data;
   logic [BLK_AW-1:0]  rd_addr;
   logic [WORD_W-1:0]  rd_data;

   logic [2:0]         nbytes;
   logic [WORD_W-1:0]  last_word;
   logic [5:0]         rnd;
   logic [WORD_W-1:0]  f_val;
   logic [WORD_W-1:0]  rsum;
   logic [WORD_W-1:0]  b_new;

   md5he_ram #(
      .WIDTH (WORD_W),
      .DEPTH (BLK_WORDS)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wcnt_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = dig_ff[oidx_ff];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 2'd3);

   // final word: keep leading bytes, marker right after them
   assign nbytes = (req_tuser > 3'd4) ? 3'd4 : req_tuser;
   always_comb begin
      case (nbytes)
         3'd0:    last_word = PAD_MARK;
         3'd1:    last_word = {16'h0000, PAD_MARK[7:0], req_tdata[7:0]};
         3'd2:    last_word = {8'h00, PAD_MARK[7:0], req_tdata[15:0]};
         3'd3:    last_word = {PAD_MARK[7:0], req_tdata[23:0]};
         default: last_word = req_tdata;
      endcase
   end

   // one MD5 round per cycle
   assign rnd     = cnt_ff[5:0] - 6'd1;
   assign rd_addr = msg_index(cnt_ff[5:0]);
   always_comb begin
      case (rnd[5:4])
         2'd0:    f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1:    f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2:    f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
   end
   assign rsum  = a_ff + f_val + ROUND_K[rnd] + rd_data;
   assign b_new = b_ff + rotl(rsum, ROT_AMT[{rnd[5:4], rnd[1:0]}]);

   always_comb begin
      state_in  = state_ff;
      wcnt_in   = wcnt_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      pad_in    = pad_ff;
      mark_in   = mark_ff;
      lenblk_in = lenblk_ff;
      final_in  = final_ff;
      ovld_in   = ovld_ff;
      oidx_in   = oidx_ff;
      chain_in  = chain_ff;
      dig_in    = dig_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      wr_en     = 1'b0;
      wr_data   = '0;

      if (ovld_ff && rsp_tready) begin
         oidx_in = oidx_ff + 2'd1;
         if (oidx_ff == 2'd3) begin
            ovld_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               wr_en   = 1'b1;
               wcnt_in = wcnt_ff + 1'b1;
               if (!req_tlast) begin
                  wr_data = req_tdata;
                  len_in  = len_ff + LEN_W'(WORD_W);
               end else begin
                  wr_data   = last_word;
                  len_in    = len_ff + {58'd0, nbytes, 3'b000};
                  pad_in    = 1'b1;
                  mark_in   = (nbytes == 3'd4);
                  lenblk_in = (nbytes != 3'd4) && (wcnt_ff < IDX_LEN_LO);
                  state_in  = S_PAD;
               end
               if (wcnt_ff == IDX_LAST) begin
                  state_in = S_CMP;
                  final_in = 1'b0;
                  cnt_in   = '0;
                  a_in     = chain_ff[0];
                  b_in     = chain_ff[1];
                  c_in     = chain_ff[2];
                  d_in     = chain_ff[3];
               end
            end
         end
         S_PAD: begin
            wr_en   = 1'b1;
            wcnt_in = wcnt_ff + 1'b1;
            if (mark_ff) begin
               wr_data   = PAD_MARK;
               mark_in   = 1'b0;
               lenblk_in = (wcnt_ff < IDX_LEN_LO);
            end else if (lenblk_ff && (wcnt_ff == IDX_LEN_LO)) begin
               wr_data = len_ff[WORD_W-1:0];
            end else if (lenblk_ff && (wcnt_ff == IDX_LAST)) begin
               wr_data = len_ff[LEN_W-1:WORD_W];
            end
            if (wcnt_ff == IDX_LAST) begin
               state_in = S_CMP;
               final_in = lenblk_ff && !mark_ff;
               cnt_in   = '0;
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
            end
         end
         S_CMP: begin
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff != '0) begin
               a_in = d_ff;
               b_in = b_new;
               c_in = b_ff;
               d_in = c_ff;
            end
            if (cnt_ff == RND_DONE) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            if (!final_ff) begin
               chain_in[0] = chain_ff[0] + a_ff;
               chain_in[1] = chain_ff[1] + b_ff;
               chain_in[2] = chain_ff[2] + c_ff;
               chain_in[3] = chain_ff[3] + d_ff;
               lenblk_in   = !mark_ff;
               state_in    = pad_ff ? S_PAD : S_IDLE;
            end else if (!ovld_ff) begin
               dig_in[0] = chain_ff[0] + a_ff;
               dig_in[1] = chain_ff[1] + b_ff;
               dig_in[2] = chain_ff[2] + c_ff;
               dig_in[3] = chain_ff[3] + d_ff;
               ovld_in   = 1'b1;
               oidx_in   = '0;
               chain_in  = INIT_VEC;
               len_in    = '0;
               wcnt_in   = '0;
               pad_in    = 1'b0;
               mark_in   = 1'b0;
               lenblk_in = 1'b0;
               final_in  = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wcnt_ff   <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
         pad_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         lenblk_ff <= 1'b0;
         final_ff  <= 1'b0;
         ovld_ff   <= 1'b0;
         oidx_ff   <= '0;
         chain_ff  <= INIT_VEC;
      end else begin
         state_ff  <= state_in;
         wcnt_ff   <= wcnt_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
         pad_ff    <= pad_in;
         mark_ff   <= mark_in;
         lenblk_ff <= lenblk_in;
         final_ff  <= final_in;
         ovld_ff   <= ovld_in;
         oidx_ff   <= oidx_in;
         chain_ff  <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
   end

endmodule

/* rtl/md5he_checker.sv */
// ----------------------------------------------------------------------------
// md5he_checker
// Port-level checks of the MD5 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module md5he_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("digest item changed while stalled");

   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser != 2'd3)
      |=> rsp_tvalid && (rsp_tuser == 2'($past(rsp_tuser) + 2'd1)))
      else $error("digest words not back to back in order");

   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd3)))
      else $error("digest end flag not on word three");

   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input still ready after final word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("engine not idle after reset");

endmodule

bind md5_hash_engine_core md5he_checker u_md5he_checker (.*);
